>>> sv/scsa_pkg.sv
// Shared types, codes and constants of the size-class slab allocator.
`default_nettype none

package scsa_pkg;

   localparam int MODE_W    = 1;
   localparam int SIZE_W    = 32;
   localparam int CLASS_F_W = 3;
   localparam int CHUNK_F_W = 3;
   localparam int SLOT_F_W  = 5;
   localparam int COUNT_W   = 11;

   localparam logic [MODE_W-1:0] MODE_FREE = 1'b1;

   // Slot size in bytes of each class, smallest first.
   localparam int TABLE_CLASSES = 7;
   localparam logic [8:0] CLASS_BYTES [TABLE_CLASSES] = '{
      9'd8, 9'd16, 9'd32, 9'd48, 9'd64, 9'd128, 9'd256
   };

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [SIZE_W-1:0]    request_size;
      logic [CLASS_F_W-1:0] free_class;
      logic [CHUNK_F_W-1:0] free_chunk;
      logic [SLOT_F_W-1:0]  free_slot;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [CLASS_F_W-1:0] granted_class;
      logic [CHUNK_F_W-1:0] granted_chunk;
      logic [SLOT_F_W-1:0]  granted_slot;
      logic [COUNT_W-1:0]   outstanding;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_CHECK,
      S_COMMIT,
      S_OPEN,
      S_REPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       scan_init;
      logic       scan_dec;
      logic       load_pick;
      logic       write_map;
      logic       open_chunk;
      logic       set_status;
      status_type status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;
      logic too_large;
      logic free_ok;
      logic none_open;
      logic class_full;
      logic scan_zero;
      logic map_full;
      logic bit_set;
   } stat_type;

endpackage

`default_nettype wire

>>> sv/scsa_ctrl.sv
// Controller state machine of the slab allocator.
`default_nettype none

module scsa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire scsa_pkg::stat_type stat,
   output scsa_pkg::cmd_type      cmd
);
   import scsa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status = ST_OK;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_free) begin
               if (stat.free_ok) begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_READ;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_BAD_FREE;
                  state_in       = S_REPLY;
               end
            end else if (stat.too_large) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_TOO_LARGE;
               state_in       = S_REPLY;
            end else if (stat.none_open) begin
               state_in = S_OPEN;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.is_free) begin
               if (stat.bit_set) begin
                  state_in = S_COMMIT;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_BAD_FREE;
                  state_in       = S_REPLY;
               end
            end else if (!stat.map_full) begin
               cmd.load_pick = 1'b1;
               state_in      = S_COMMIT;
            end else if (!stat.scan_zero) begin
               cmd.scan_dec = 1'b1;
               state_in     = S_READ;
            end else if (stat.class_full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_FULL;
               state_in       = S_REPLY;
            end else begin
               state_in = S_OPEN;
            end
         end
         S_COMMIT: begin
            cmd.write_map  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_in       = S_REPLY;
         end
         S_OPEN: begin
            cmd.open_chunk = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_in       = S_REPLY;
         end
         S_REPLY: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/scsa_dpath.sv
// Datapath of the slab allocator: request registers, bitmap memory and counters.
`default_nettype none

module scsa_dpath #(
   parameter int NUM_CLASSES      = 7,
   parameter int SLOTS_PER_CHUNK  = 32,
   parameter int CHUNKS_PER_CLASS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire scsa_pkg::req_type  req_data,
   input  wire scsa_pkg::cmd_type  cmd,
   output scsa_pkg::stat_type      stat,
   output scsa_pkg::rsp_type       rsp_data
);
   import scsa_pkg::*;

   localparam int LIVE    = (NUM_CLASSES < TABLE_CLASSES) ? NUM_CLASSES : TABLE_CLASSES;
   localparam int CLASS_W = (LIVE > 1) ? $clog2(LIVE) : 1;
   localparam int CHUNK_W = (CHUNKS_PER_CLASS > 1) ? $clog2(CHUNKS_PER_CLASS) : 1;
   localparam int SLOT_W  = (SLOTS_PER_CHUNK > 1) ? $clog2(SLOTS_PER_CHUNK) : 1;
   localparam int OPEN_W  = $clog2(CHUNKS_PER_CLASS + 1);
   localparam int ADDR_W  = CLASS_W + CHUNK_W;
   localparam int DEPTH   = 1 << ADDR_W;

   // Request registers.
   logic                       is_free_ff;
   logic                       too_large_ff;
   logic                       class_ok_ff;
   logic                       req_ok_ff;
   logic [CLASS_W-1:0]         class_ff;
   logic [CHUNK_W-1:0]         scan_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic [SLOTS_PER_CHUNK-1:0] mask_ff;
   status_type                 status_ff;

   // Allocator state.
   logic [OPEN_W-1:0]          opened_ff [LIVE];
   logic [COUNT_W-1:0]         count_ff;
   logic [SLOTS_PER_CHUNK-1:0] map_ff [DEPTH];
   logic [SLOTS_PER_CHUNK-1:0] rd_data_ff;

   // Size class lookup at accept time.
   logic [CLASS_W-1:0] size_class;
   logic               size_fits;
   always_comb begin
      size_class = '0;
      size_fits  = 1'b0;
      for (int c = LIVE - 1; c >= 0; c--) begin
         if (req_data.request_size <= SIZE_W'(CLASS_BYTES[c])) begin
            size_class = CLASS_W'(c);
            size_fits  = 1'b1;
         end
      end
   end

   logic in_class_ok;
   logic in_chunk_ok;
   logic in_slot_ok;
   logic in_free;
   assign in_free     = (req_data.mode == MODE_FREE);
   assign in_class_ok = int'(req_data.free_class) < LIVE;
   assign in_chunk_ok = int'(req_data.free_chunk) < CHUNKS_PER_CLASS;
   assign in_slot_ok  = int'(req_data.free_slot) < SLOTS_PER_CHUNK;

   // Opened-chunk count of the selected class.
   logic [OPEN_W-1:0] opened_sel;
   assign opened_sel = class_ok_ff ? opened_ff[class_ff] : '0;

   // Lowest clear slot of the map just read.
   logic [SLOTS_PER_CHUNK-1:0] free_bits;
   logic [SLOTS_PER_CHUNK-1:0] pick_onehot;
   logic [SLOT_W-1:0]          pick_idx;
   always_comb begin
      free_bits   = ~rd_data_ff;
      pick_onehot = free_bits & (~free_bits + SLOTS_PER_CHUNK'(1));
      pick_idx    = '0;
      for (int i = 0; i < SLOTS_PER_CHUNK; i++) begin
         pick_idx = pick_idx | (pick_onehot[i] ? SLOT_W'(i) : '0);
      end
   end

   // Memory ports.
   logic [ADDR_W-1:0]          rd_addr;
   logic [ADDR_W-1:0]          wr_addr;
   logic [SLOTS_PER_CHUNK-1:0] wr_data;
   logic                       wr_en;
   assign rd_addr = {class_ff, scan_ff};
   assign wr_en   = cmd.write_map | cmd.open_chunk;
   assign wr_addr = cmd.open_chunk ? {class_ff, CHUNK_W'(opened_sel)} : rd_addr;
   assign wr_data = cmd.open_chunk ? SLOTS_PER_CHUNK'(1) : (rd_data_ff ^ mask_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_ff[rd_addr];
   end

   // Request and scan registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         is_free_ff   <= in_free;
         too_large_ff <= !size_fits;
         class_ok_ff  <= in_free ? in_class_ok : size_fits;
         req_ok_ff    <= in_class_ok & in_chunk_ok & in_slot_ok;
         class_ff     <= in_free ? CLASS_W'(req_data.free_class) : size_class;
         scan_ff      <= CHUNK_W'(req_data.free_chunk);
         mask_ff      <= SLOTS_PER_CHUNK'(1) << req_data.free_slot;
         slot_ff      <= '0;
      end
      if (cmd.scan_init && !is_free_ff) begin
         scan_ff <= CHUNK_W'(opened_sel - OPEN_W'(1));
      end
      if (cmd.scan_dec) begin
         scan_ff <= scan_ff - CHUNK_W'(1);
      end
      if (cmd.load_pick) begin
         slot_ff <= pick_idx;
         mask_ff <= pick_onehot;
      end
      if (cmd.open_chunk) begin
         scan_ff <= CHUNK_W'(opened_sel);
         slot_ff <= '0;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   // Per-class open counts and the outstanding count.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < LIVE; c++) begin
            opened_ff[c] <= '0;
         end
         count_ff <= '0;
      end else begin
         if (cmd.open_chunk) begin
            opened_ff[class_ff] <= opened_sel + OPEN_W'(1);
            count_ff            <= count_ff + COUNT_W'(1);
         end
         if (cmd.write_map) begin
            count_ff <= is_free_ff ? (count_ff - COUNT_W'(1)) : (count_ff + COUNT_W'(1));
         end
      end
   end

   always_comb begin
      stat.is_free    = is_free_ff;
      stat.too_large  = too_large_ff;
      stat.free_ok    = req_ok_ff && (OPEN_W'(scan_ff) < opened_sel);
      stat.none_open  = (opened_sel == '0);
      stat.class_full = (int'(opened_sel) >= CHUNKS_PER_CLASS);
      stat.scan_zero  = (scan_ff == '0);
      stat.map_full   = &rd_data_ff;
      stat.bit_set    = |(rd_data_ff & mask_ff);
   end

   logic granted;
   assign granted = (status_ff == ST_OK) && !is_free_ff;

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.granted_class = granted ? CLASS_F_W'(class_ff) : '0;
      rsp_data.granted_chunk = granted ? CHUNK_F_W'(scan_ff) : '0;
      rsp_data.granted_slot  = granted ? SLOT_F_W'(slot_ff) : '0;
      rsp_data.outstanding   = count_ff;
   end

endmodule

`default_nettype wire

>>> sv/size_class_slab_allocator.sv
// Top level of the size-class slab allocator.
//
//   Channel   Ports                        Transfer when
//   request   start, busy, req_data        start high and busy low at a clock edge
//   response  rsp_valid, rsp_data          rsp_valid high, one cycle per request
//
// One request is worked on at a time; busy stays high from the transfer until the
// response cycle has ended, then goes low in the idle state, where the next transfer
// is taken. A rejected oversize allocation or a free naming a bad class or an
// unopened chunk is answered from decode. Any other free reads its chunk bitmap and
// clears the bit if set, else is rejected. An allocation reads the opened chunk
// bitmaps, newest first, until one has a clear slot and sets its lowest clear bit;
// if none is open or all are full it opens a new chunk, or replies full when the
// class has none left. Each bitmap read goes through the registered read port of the
// bitmap memory. Reset is synchronous and clears the open counts and the outstanding
// count; the bitmaps need no clearing pass because a chunk is written whole when it
// is opened and never read before. The response cannot be stalled by the receiver.
`default_nettype none

module size_class_slab_allocator #(
   parameter int NUM_CLASSES      = 7,
   parameter int SLOTS_PER_CHUNK  = 32,
   parameter int CHUNKS_PER_CLASS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire scsa_pkg::req_type req_data,
   output logic                   rsp_valid,
   output scsa_pkg::rsp_type      rsp_data
);
   import scsa_pkg::*;

   // Command and status between the sequencer and the datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller walks each request through decode, bitmap reads, the write-back or
   // the opening of a chunk, and the response cycle.
   scsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the request, the per-chunk slot bitmaps, the open counts and
   // the outstanding count, and builds the response fields.
   scsa_dpath #(
      .NUM_CLASSES      (NUM_CLASSES),
      .SLOTS_PER_CHUNK  (SLOTS_PER_CHUNK),
      .CHUNKS_PER_CLASS (CHUNKS_PER_CLASS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> sv/scsa_checker.sv
// Port-level checker of the slab allocator and its bind to the top level.
`default_nettype none

module scsa_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire scsa_pkg::rsp_type rsp_data
);
   import scsa_pkg::*;

   // The response strobe is a single-cycle pulse.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // A transfer raises busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy not raised after a request transfer");

   // A response only appears while a request is in flight, and busy drops after it.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy ##1 !busy)
      else $error("response outside a busy window");

   // A failed request grants nothing.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.granted_class == '0 && rsp_data.granted_chunk == '0 &&
          rsp_data.granted_slot == '0))
      else $error("grant fields set on a failed request");

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (.*);

`default_nettype wire

>>> tb/tb_size_class_slab_allocator.sv
// Self-checking testbench for the size-class slab allocator, with a shadow model of its slab store.

module tb_size_class_slab_allocator;
   import scsa_pkg::*;

   localparam int NUM_CLASSES      = 7;
   localparam int SLOTS_PER_CHUNK  = 32;
   localparam int CHUNKS_PER_CLASS = 8;

   // Shadow copy of the allocator. Each accepted request is applied here at the
   // moment of its transfer, and the reply it must produce is queued. Replies from
   // the block are then compared against the oldest queued one, field by field.
   class slab_ledger;
      logic [SLOTS_PER_CHUNK-1:0] maps [NUM_CLASSES][CHUNKS_PER_CLASS];
      int                         opened [NUM_CLASSES];
      logic [COUNT_W-1:0]         live;
      rsp_type                    expected_replies [$];
      // Every slot currently handed out, packed as {class, chunk, slot}. The
      // stimulus draws from this list to build frees that really hit a set bit.
      logic [10:0]                held_slots [$];
      int unsigned                errors;
      int unsigned                by_status [4];
      int unsigned                frees_ok;
      int unsigned                peak_live;

      function new();
         foreach (maps[c, k]) maps[c][k] = '0;
         foreach (opened[c]) opened[c] = 0;
         foreach (by_status[i]) by_status[i] = 0;
         live      = '0;
         errors    = 0;
         frees_ok  = 0;
         peak_live = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      c;
         int      k;
         int      s;
         int      gk;
         int      gs;
         bit      found;
         e        = '0;
         e.status = ST_BAD_FREE;
         found    = 1'b0;
         gk       = 0;
         gs       = 0;
         if (r.mode == MODE_FREE) begin
            c = r.free_class;
            k = r.free_chunk;
            s = r.free_slot;
            // A free is honored only for an opened chunk of a real class whose
            // bit is set; anything else leaves the store untouched.
            if (c < NUM_CLASSES) begin
               if (k < opened[c] && maps[c][k][s]) begin
                  maps[c][k][s] = 1'b0;
                  live          = live - 1'b1;
                  e.status      = ST_OK;
                  frees_ok++;
                  for (int i = 0; i < held_slots.size(); i++) begin
                     if (held_slots[i] == {3'(c), 3'(k), 5'(s)}) begin
                        held_slots.delete(i);
                        break;
                     end
                  end
               end
            end
         end else if (r.request_size > CLASS_BYTES[NUM_CLASSES-1]) begin
            e.status = ST_TOO_LARGE;
         end else begin
            c = 0;
            while (r.request_size > CLASS_BYTES[c]) c++;
            // Newest opened chunk first; the first one with a clear bit wins.
            for (k = opened[c] - 1; k >= 0; k--) begin
               if (!found && maps[c][k] != '1) begin
                  found = 1'b1;
                  gk    = k;
                  gs    = 0;
                  while (maps[c][k][gs]) gs++;
               end
            end
            if (!found && opened[c] < CHUNKS_PER_CLASS) begin
               found = 1'b1;
               gk    = opened[c];
               gs    = 0;
               maps[c][gk] = '0;
               opened[c]++;
            end
            if (found) begin
               maps[c][gk][gs] = 1'b1;
               live            = live + 1'b1;
               e.status        = ST_OK;
               e.granted_class = 3'(c);
               e.granted_chunk = 3'(gk);
               e.granted_slot  = 5'(gs);
               held_slots.push_back({3'(c), 3'(gk), 5'(gs)});
            end else begin
               e.status = ST_FULL;
            end
         end
         e.outstanding = live;
         if (live > peak_live) peak_live = live;
         by_status[int'(e.status)]++;
         expected_replies.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_reply(rsp_type a);
         rsp_type e;
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: reply with nothing expected, status %0d class %0d chunk %0d slot %0d",
                     $time, a.status, a.granted_class, a.granted_chunk, a.granted_slot);
         end else begin
            e = expected_replies.pop_front();
            compare_field("status", e.status, a.status);
            compare_field("granted_class", e.granted_class, a.granted_class);
            compare_field("granted_chunk", e.granted_chunk, a.granted_chunk);
            compare_field("granted_slot", e.granted_slot, a.granted_slot);
            compare_field("outstanding", e.outstanding, a.outstanding);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   slab_ledger ledger;

   size_class_slab_allocator #(
      .NUM_CLASSES      (NUM_CLASSES),
      .SLOTS_PER_CHUNK  (SLOTS_PER_CHUNK),
      .CHUNKS_PER_CLASS (CHUNKS_PER_CLASS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Period of 8: four units high, four units low.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Both channels are watched at the rising edge, where the block's registered
   // outputs still show their values from before the edge. A reply is checked
   // before a new transfer is noted, although busy keeps the two apart anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) ledger.check_reply(rsp_data);
         if (start && !busy) ledger.note_request(req_data);
      end
   end

   // Presents one request from a falling edge and holds it until the rising edge
   // at which busy is low, then returns at the next falling edge. Start is left
   // high so that back-to-back requests need no second assignment in one step.
   task automatic send_request(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Sender gap: lowers start, then waits for the given number of falling edges.
   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stops the sender until every reply owed has come back. The extra falling
   // edge keeps the lowering of start apart from the next raising of it.
   task automatic wait_for_replies();
      start <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic req_type alloc_request(input logic [31:0] size);
      req_type r;
      r              = '0;
      r.request_size = size;
      return r;
   endfunction

   function automatic req_type free_request(input int c, input int k, input int s);
      req_type r;
      r            = '0;
      r.mode       = MODE_FREE;
      r.free_class = 3'(c);
      r.free_chunk = 3'(k);
      r.free_slot  = 5'(s);
      return r;
   endfunction

   // One random request. Allocations mostly ask for sizes that land in the
   // focus class, so that class can be driven all the way to full; the rest
   // spread over all classes or exceed the largest. Frees mostly name a slot
   // that is really held, the rest are arbitrary and usually rejected. The
   // field that the mode ignores is filled with noise so every bit toggles.
   function automatic req_type build_request(input int focus, input int alloc_pct,
                                             input int focus_pct);
      req_type     r;
      int          pick;
      int unsigned lo;
      logic [10:0] held;
      r            = '0;
      r.free_class = 3'($urandom);
      r.free_chunk = 3'($urandom);
      r.free_slot  = 5'($urandom);
      if ($urandom_range(99) < alloc_pct) begin
         pick = $urandom_range(99);
         lo   = (focus == 0) ? 0 : CLASS_BYTES[focus-1] + 1;
         if (pick < focus_pct)
            r.request_size = $urandom_range(CLASS_BYTES[focus], lo);
         else if (pick < focus_pct + (100 - focus_pct) * 2 / 3)
            r.request_size = $urandom_range(CLASS_BYTES[NUM_CLASSES-1], 0);
         else
            r.request_size = $urandom_range(32'hffff_ffff, 257);
      end else begin
         r.mode         = MODE_FREE;
         r.request_size = $urandom;
         if (ledger.held_slots.size() != 0 && $urandom_range(99) < 80) begin
            held         = ledger.held_slots[$urandom_range(ledger.held_slots.size() - 1)];
            r.free_class = held[10:8];
            r.free_chunk = held[7:5];
            r.free_slot  = held[4:0];
         end
      end
      return r;
   endfunction

   initial begin
      req_type directed [$];
      // Random phases: item count, focus class, share of allocations, share of
      // allocations aimed at the focus class. The second phase fills one class
      // past its last chunk; the fifth is free-heavy and drains the store.
      int      ph_items [6]  = '{250, 400, 250, 250, 300, 300};
      int      ph_focus [6]  = '{0, 3, 5, 6, 2, 1};
      int      ph_alloc [6]  = '{60, 95, 50, 70, 30, 60};
      int      ph_aim [6]    = '{80, 95, 80, 85, 70, 85};
      bit      idle_on;

      ledger   = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: every class boundary from size zero upward, both ways of
      // being too large, and each kind of rejected free next to a good one. The
      // re-allocation after the first free shows the lowest clear bit reused.
      directed.push_back(alloc_request(32'd0));
      directed.push_back(alloc_request(32'd8));
      directed.push_back(alloc_request(32'd9));
      directed.push_back(alloc_request(32'd16));
      directed.push_back(alloc_request(32'd17));
      directed.push_back(alloc_request(32'd32));
      directed.push_back(alloc_request(32'd33));
      directed.push_back(alloc_request(32'd48));
      directed.push_back(alloc_request(32'd49));
      directed.push_back(alloc_request(32'd64));
      directed.push_back(alloc_request(32'd65));
      directed.push_back(alloc_request(32'd128));
      directed.push_back(alloc_request(32'd129));
      directed.push_back(alloc_request(32'd256));
      directed.push_back(alloc_request(32'd257));
      directed.push_back(alloc_request(32'hffff_ffff));
      directed.push_back(alloc_request(32'h8000_0000));
      directed.push_back(free_request(0, 0, 0));
      directed.push_back(free_request(0, 0, 0));
      directed.push_back(alloc_request(32'd1));
      directed.push_back(free_request(7, 0, 0));
      directed.push_back(free_request(0, 5, 0));
      directed.push_back(free_request(2, 0, 31));
      directed.push_back(free_request(6, 0, 1));
      directed[directed.size() - 1].request_size = 32'hffff_ffff;
      directed.push_back(free_request(6, 7, 31));

      foreach (directed[i]) begin
         send_request(directed[i]);
         if ($urandom_range(99) < 30) hold_off($urandom_range(24, 1));
      end
      wait_for_replies();

      // Random part. The fourth phase runs with no sender gaps at all, so the
      // block sees requests back to back for a long stretch.
      for (int p = 0; p < 6; p++) begin
         idle_on = (p != 3);
         for (int n = 0; n < ph_items[p]; n++) begin
            send_request(build_request(ph_focus[p], ph_alloc[p], ph_aim[p]));
            if (idle_on && $urandom_range(99) < 30) hold_off($urandom_range(24, 1));
         end
         if (p % 2 == 1) wait_for_replies();
      end

      // Let every reply come back, then give the block a little longer in case
      // it sends anything it should not.
      wait_for_replies();
      repeat (40) @(posedge clock);
      if (ledger.pending() != 0) begin
         ledger.errors++;
         $display("%0t: %0d replies never arrived", $time, ledger.pending());
      end

      $display("Ran %0d requests: %0d ok (%0d of them frees), %0d too large, %0d class full,",
               ledger.by_status[0] + ledger.by_status[1] + ledger.by_status[2]
                  + ledger.by_status[3],
               ledger.by_status[0], ledger.frees_ok, ledger.by_status[1],
               ledger.by_status[2]);
      $display("%0d rejected frees; at most %0d slots were held at once.",
               ledger.by_status[3], ledger.peak_live);
      if (ledger.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Far beyond the slowest correct run: under 2000 requests, each with its time in
   // the block plus a random sender gap.
   initial begin
      #(8 * 600_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
